@@ hdl/sbs_pkg.sv @@
// Shared types, constants and the reciprocal table for the background subtractor.
package sbs_pkg;

   localparam int MAX_PIXELS = 16384;
   localparam int WINDOW_MAX = 8;
   localparam int POS_W      = $clog2(MAX_PIXELS);
   localparam int SLOT_W     = $clog2(WINDOW_MAX);
   localparam int FRAMES_W   = 4;
   localparam int FP_W       = 15;
   localparam int PIX_W      = 16;
   localparam int SUM_W      = 19;
   localparam int RECIP_SH   = 22;
   localparam int RECIP_W    = RECIP_SH + 1;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam int CSR_W      = 15;

   // Register indexes
   localparam logic CSR_WINDOW = 1'b0;
   localparam logic CSR_FRAME  = 1'b1;

   // How the running sum is updated
   localparam logic [1:0] KIND_FIRST = 2'd0;
   localparam logic [1:0] KIND_PART  = 2'd1;
   localparam logic [1:0] KIND_FULL  = 2'd2;

   typedef struct packed {
      logic [PIX_W-1:0]    pix;
      logic [POS_W-1:0]    pos;
      logic [SLOT_W-1:0]   slot;
      logic [1:0]          kind;
      logic [FRAMES_W-1:0] count;
      logic                last;
   } sbs_item_type;

   // ceil(2^22 / count), exact floor division for dividends below 2^19
   function automatic logic [RECIP_W-1:0] sbs_recip(input logic [FRAMES_W-1:0] count);
      logic [RECIP_W-1:0] m;
      begin
         case (count)
            4'd1: m = 23'd4194304;
            4'd2: m = 23'd2097152;
            4'd3: m = 23'd1398102;
            4'd4: m = 23'd1048576;
            4'd5: m = 23'd838861;
            4'd6: m = 23'd699051;
            4'd7: m = 23'd599187;
            4'd8: m = 23'd524288;
            default: m = 23'd4194304;
         endcase
         return m;
      end
   endfunction

endpackage

@@ hdl/sbs_front.sv @@
// Front end: configuration, stream position tracking and item classification.
module sbs_front import sbs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [PIX_W-1:0]    req_pixel,
   input  logic                req_restart,
   input  logic                q_full,
   output logic                q_push,
   output sbs_item_type        q_item
);

   logic [FRAMES_W-1:0] window_ff, window_in;
   logic [FP_W-1:0]     frame_ff, frame_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [FRAMES_W-1:0] seen_ff, seen_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   logic [FRAMES_W-1:0] w_eff, fs, cnt_raw;
   logic [FP_W-1:0]     fp_eff, pos_next;
   logic [POS_W-1:0]    pos;
   logic [SLOT_W-1:0]   slot;
   logic                last;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   // Clamp configuration to legal ranges
   always_comb begin
      if (window_ff == '0) w_eff = FRAMES_W'(1);
      else if (window_ff > FRAMES_W'(WINDOW_MAX)) w_eff = FRAMES_W'(WINDOW_MAX);
      else w_eff = window_ff;
      if (frame_ff == '0) fp_eff = FP_W'(1);
      else if (frame_ff > FP_W'(MAX_PIXELS)) fp_eff = FP_W'(MAX_PIXELS);
      else fp_eff = frame_ff;
   end

   // Classify the incoming pixel
   always_comb begin
      fs   = req_restart ? '0 : seen_ff;
      pos  = req_restart ? '0 : pos_ff;
      slot = req_restart ? '0 : slot_ff;
      if ({1'b0, slot} >= w_eff) slot = '0;
      cnt_raw = fs + FRAMES_W'(1);
      q_item.pix   = req_pixel;
      q_item.pos   = pos;
      q_item.slot  = slot;
      q_item.count = (cnt_raw > w_eff) ? w_eff : cnt_raw;
      if (fs == '0) q_item.kind = KIND_FIRST;
      else if (fs >= w_eff) q_item.kind = KIND_FULL;
      else q_item.kind = KIND_PART;
      pos_next = {1'b0, pos} + FP_W'(1);
      last = (pos_next >= fp_eff);
      q_item.last = last;
   end

   // Take register writes and advance position, slot and frame count
   always_comb begin
      window_in = window_ff;
      frame_in  = frame_ff;
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      slot_in   = slot_ff;
      if (csr_write) begin
         if (csr_index == CSR_WINDOW) window_in = csr_data[FRAMES_W-1:0];
         else frame_in = csr_data;
         pos_in  = '0;
         seen_in = '0;
         slot_in = '0;
      end else if (q_push) begin
         if (last) begin
            pos_in  = '0;
            slot_in = ({1'b0, slot} + FRAMES_W'(1) >= w_eff) ? '0 : slot + SLOT_W'(1);
            seen_in = (fs < w_eff) ? fs + FRAMES_W'(1) : fs;
         end else begin
            pos_in  = pos_next[POS_W-1:0];
            slot_in = slot;
            seen_in = fs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= FRAMES_W'(WINDOW_MAX);
         frame_ff  <= FP_W'(MAX_PIXELS);
         pos_ff    <= '0;
         seen_ff   <= '0;
         slot_ff   <= '0;
      end else begin
         window_ff <= window_in;
         frame_ff  <= frame_in;
         pos_ff    <= pos_in;
         seen_ff   <= seen_in;
         slot_ff   <= slot_in;
      end
   end

endmodule

@@ hdl/sbs_queue.sv @@
// Two-entry queue between front and back end.
module sbs_queue import sbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  sbs_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output sbs_item_type head
);

   sbs_item_type entry_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = entry_ff[rd_ff];

   // Store pushed items
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_item;
   end

   // Track fill level and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         if (push && !pop) cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

endmodule

@@ hdl/sbs_back.sv @@
// Back end: history and sum stores, mean subtraction and result register.
module sbs_back import sbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  sbs_item_type     q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_corrected,
   output logic             rsp_frame_end
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUM  = 3'd1;
   localparam logic [2:0] ST_DIFF = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [PIX_W-1:0] hist_mem [WINDOW_MAX*MAX_PIXELS];
   logic [SUM_W-1:0] sum_mem  [MAX_PIXELS];

   logic [2:0]         state_ff, state_in;
   sbs_item_type       item_ff;
   logic [PIX_W-1:0]   hist_rd_ff;
   logic [SUM_W-1:0]   sum_rd_ff, sum_ff, sum_in, diff_ff, pc;
   logic [RECIP_W-1:0] recip_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   corr_ff;
   logic               fend_ff;
   logic               out_load;

   assign q_pop         = (state_ff == ST_IDLE) && q_not_empty;
   assign out_load      = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_corrected = corr_ff;
   assign rsp_frame_end = fend_ff;

   // Update the running sum and scale the pixel by the count
   always_comb begin
      case (item_ff.kind)
         KIND_FIRST: sum_in = SUM_W'(item_ff.pix);
         KIND_FULL:  sum_in = sum_rd_ff - SUM_W'(hist_rd_ff) + SUM_W'(item_ff.pix);
         default:    sum_in = sum_rd_ff + SUM_W'(item_ff.pix);
      endcase
      pc = SUM_W'(item_ff.pix) * SUM_W'(item_ff.count);
   end

   // Read and write the stores
   always_ff @(posedge clock) begin
      if (q_pop) begin
         hist_rd_ff <= hist_mem[{q_head.slot, q_head.pos}];
         sum_rd_ff  <= sum_mem[q_head.pos];
      end
      if (state_ff == ST_SUM) begin
         hist_mem[{item_ff.slot, item_ff.pos}] <= item_ff.pix;
         sum_mem[item_ff.pos] <= sum_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) item_ff <= q_head;
      if (state_ff == ST_SUM) sum_ff <= sum_in;
      if (state_ff == ST_DIFF) begin
         diff_ff  <= (pc > sum_ff) ? pc - sum_ff : '0;
         recip_ff <= sbs_recip(item_ff.count);
      end
      if (state_ff == ST_MUL) prod_ff <= PROD_W'(diff_ff) * PROD_W'(recip_ff);
      if (out_load) begin
         corr_ff <= prod_ff[RECIP_SH +: PIX_W];
         fend_ff <= item_ff.last;
      end
   end

   // Sequence one item at a time
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (q_not_empty) state_in = ST_SUM;
         ST_SUM:  state_in = ST_DIFF;
         ST_DIFF: state_in = ST_MUL;
         ST_MUL:  state_in = ST_OUT;
         ST_OUT:  if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/sliding_mean_background_subtract_core.sv @@
// Top level of the sliding-mean background subtractor.
// The back end takes one pixel at a time through its read, sum, diff,
// multiply and output steps on the single history/sum store port.
// Reset: synchronous; window 8, frame 16384 pixels, stream position cleared.
// Store contents are not cleared; an entry's value is used only after it is written.
module sliding_mean_background_subtract_core import sbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_restart,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_corrected,
   output logic             rsp_frame_end
);

   sbs_item_type push_item, head;
   logic         push, full, pop, not_empty;

   sbs_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid, .req_ready, .req_pixel, .req_restart,
      .q_full(full), .q_push(push), .q_item(push_item)
   );

   sbs_queue u_queue (
      .clock, .reset, .push, .push_item, .full,
      .pop, .not_empty, .head
   );

   sbs_back u_back (
      .clock, .reset, .q_not_empty(not_empty), .q_head(head), .q_pop(pop),
      .rsp_valid, .rsp_ready, .rsp_corrected, .rsp_frame_end
   );

endmodule

@@ verif/testbench.sv @@
// Testbench for the sliding-mean background subtractor core.
`timescale 1ns / 100ps

module testbench;
   import sbs_pkg::*;

   typedef struct {
      logic [PIX_W-1:0] corrected;
      logic             frame_end;
   } bg_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write = 1'b0;
   logic             csr_index = CSR_WINDOW;
   logic [CSR_W-1:0] csr_data = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [PIX_W-1:0] req_pixel = '0;
   logic             req_restart = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [PIX_W-1:0] rsp_corrected;
   logic             rsp_frame_end;

   // Predicted background state and registers
   logic [PIX_W-1:0] bg_history [WINDOW_MAX][MAX_PIXELS];
   logic [SUM_W-1:0] bg_sum [MAX_PIXELS];
   int unsigned      bg_pos, bg_seen, bg_slot;
   logic [3:0]       window_reg;
   logic [FP_W-1:0]  frame_reg;

   bg_result_type expected_q[$];
   int          fail_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          recv_hold = 0;
   int          quiet_cycles = 0;

   sliding_mean_background_subtract_core dut (.*);

   always #2 clock = ~clock;

   // Work out the corrected pixel for one accepted transfer
   function automatic bg_result_type predict_corrected(logic [PIX_W-1:0] pix, logic rst);
      int unsigned   w, fp, pos, slot, total, count;
      longint        diff;
      bg_result_type r;
      w  = (window_reg == 0) ? 1 : (window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg;
      fp = (frame_reg == 0) ? 1 : (frame_reg > MAX_PIXELS) ? MAX_PIXELS : frame_reg;
      if (rst) begin
         bg_pos = 0; bg_seen = 0; bg_slot = 0;
      end
      pos  = (bg_pos >= MAX_PIXELS) ? MAX_PIXELS - 1 : bg_pos;
      slot = (bg_slot >= w) ? 0 : bg_slot;
      if (bg_seen == 0)
         total = pix;
      else if (bg_seen >= w)
         total = bg_sum[pos] - bg_history[slot][pos] + pix;
      else
         total = bg_sum[pos] + pix;
      count = (bg_seen + 1 > w) ? w : bg_seen + 1;
      bg_sum[pos] = SUM_W'(total);
      bg_history[slot][pos] = pix;
      diff = longint'(pix) * count - total;
      r.corrected = (diff > 0) ? PIX_W'(diff / count) : '0;
      r.frame_end = (pos + 1 >= fp);
      if (r.frame_end) begin
         bg_pos = 0;
         bg_slot = (slot + 1 >= w) ? 0 : slot + 1;
         if (bg_seen < w) bg_seen++;
      end else begin
         bg_pos = pos + 1;
      end
      return r;
   endfunction

   // Offer one pixel and hold it until the transfer
   task automatic send_pixel(logic [PIX_W-1:0] pix, logic rst);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_pixel   <= pix;
      req_restart <= rst;
      do @(posedge clock); while (!req_ready);
      expected_q = {expected_q, predict_corrected(pix, rst)};
   endtask

   // Wait for the block to drain, then write one register
   task automatic write_reg(logic idx, logic [CSR_W-1:0] val);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_WINDOW) window_reg = val[3:0];
      else                   frame_reg  = val;
      bg_pos = 0; bg_seen = 0; bg_slot = 0;
   endtask

   task automatic test_directed;
      write_reg(CSR_WINDOW, 15'd3);
      write_reg(CSR_FRAME, 15'd2);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h8000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0001, 1'b0);
      // restart in the middle of a frame
      send_pixel(16'h1234, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
   endtask

   task automatic test_register_limits;
      write_reg(CSR_WINDOW, 15'd0);
      write_reg(CSR_FRAME, 15'd0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      write_reg(CSR_WINDOW, 15'd15);
      write_reg(CSR_FRAME, 15'h7FFF);
      send_pixel(16'hAAAA, 1'b0);
      send_pixel(16'h5555, 1'b0);
      write_reg(CSR_FRAME, 15'd1);
      repeat (10) send_pixel(16'($urandom), 1'b0);
   endtask

   task automatic run_random(int items, int pause_at);
      logic [PIX_W-1:0] pix;
      write_reg(CSR_WINDOW, CSR_W'($urandom_range(15)));
      write_reg(CSR_FRAME, ($urandom_range(9) == 0) ? '0 : CSR_W'($urandom_range(1, 6)));
      for (int i = 0; i < items; i++) begin
         if (i == pause_at) begin
            req_valid <= 1'b0;
            while (expected_q.size() != 0) @(posedge clock);
         end
         pix = ($urandom_range(3) == 0) ? 16'($urandom_range(15)) : 16'($urandom);
         send_pixel(pix, $urandom_range(99) < 3);
      end
   endtask

   task automatic test_random_traffic;
      send_idle_pct = 7;  recv_idle_pct = 54;
      run_random(70, 30);
      run_random(60, -1);
      send_idle_pct = 54; recv_idle_pct = 7;
      run_random(70, -1);
      run_random(60, 20);
      send_idle_pct = 0;  recv_idle_pct = 0;
      run_random(70, -1);
   endtask

   // Stall the result side long enough to back up the input
   task automatic test_backpressure;
      write_reg(CSR_WINDOW, 15'd8);
      write_reg(CSR_FRAME, 15'd3);
      recv_hold = 300;
      repeat (30) send_pixel(16'($urandom), 1'b0);
   endtask

   // Result side readiness
   always @(posedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      bg_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("result with no prediction waiting");
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_corrected !== want.corrected) begin
               $error("corrected: expected %0d, got %0d", want.corrected, rsp_corrected);
               fail_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0d, got %0d", want.frame_end, rsp_frame_end);
               fail_count++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      window_reg = 8; frame_reg = 16384;
      bg_pos = 0; bg_seen = 0; bg_slot = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed;
      test_register_limits;
      test_backpressure;
      test_random_traffic;
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
